// ----- rtl/assert_macros.svh -----
// Assertion macros included by the gain scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition is followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/fpd_pkg.sv -----
package fpd_pkg;

    // Divider widths: quotient bits, dividend bits, divisor bits.
    localparam int DIV_QW = 20;
    localparam int DIV_DW = 19;
    localparam int DIV_SW = 18;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EFS   = 3'd0;
    localparam logic [2:0] CFG_RFS   = 3'd1;
    localparam logic [2:0] CFG_KPSPN = 3'd2;
    localparam logic [2:0] CFG_KDSPN = 3'd3;
    localparam logic [2:0] CFG_KPOFS = 3'd4;
    localparam logic [2:0] CFG_KDOFS = 3'd5;

    // Reset values of the full-scale registers.
    localparam logic [14:0] EFS_RESET = 15'd30;
    localparam logic [14:0] RFS_RESET = 15'd1;

    // Unit weight in Q1.16 and the reciprocal of three in Q0.19.
    localparam logic [16:0] W_ONE  = 17'd65536;
    localparam logic [18:0] RECIP3 = 19'd174763;

    // Rule tables, indexed by error point then rate point.
    localparam logic [2:0] KP_RULE [7][7] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
        '{3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3},
        '{3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4},
        '{3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5},
        '{3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6},
        '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6}
    };
    localparam logic [2:0] KD_RULE [7][7] = '{
        '{3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2},
        '{3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2},
        '{3'd6, 3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2},
        '{3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1},
        '{3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0},
        '{3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0}
    };

    // Rule lookup: sel low picks the Kp table, high the Kd table.
    function automatic logic [2:0] rule_at(logic sel, logic [2:0] ei, logic [2:0] di);
        logic [2:0] val;
        val = 3'd0;
        if (ei < 3'd7 && di < 3'd7) begin
            val = sel ? KD_RULE[ei][di] : KP_RULE[ei][di];
        end
        return val;
    endfunction

    // Sequencer states.
    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_PREP = 14'b00000000000010,
        S_ECLS = 14'b00000000000100,
        S_EDIV = 14'b00000000001000,
        S_EFIN = 14'b00000000010000,
        S_RCLS = 14'b00000000100000,
        S_RDIV = 14'b00000001000000,
        S_RFIN = 14'b00000010000000,
        S_GS0  = 14'b00000100000000,
        S_GS1  = 14'b00001000000000,
        S_GT   = 14'b00010000000000,
        S_GQ   = 14'b00100000000000,
        S_GADD = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

endpackage

// ----- rtl/fpd_div.sv -----
module fpd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fpd_pkg::DIV_DW-1:0]   i_dividend,
    input  logic [fpd_pkg::DIV_SW-1:0]   i_divisor,
    output logic                         o_done,
    output logic [fpd_pkg::DIV_QW-1:0]   o_quo,
    output logic [fpd_pkg::DIV_SW-1:0]   o_rem
);
    import fpd_pkg::*;

    localparam int CW = $clog2(DIV_QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DIV_SW-1:0] r_rem;
    logic [DIV_QW-1:0] r_dvd;
    logic [DIV_QW-1:0] r_quo;
    logic [DIV_SW-1:0] r_div;
    logic [DIV_SW:0]   trial;
    logic              take;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {r_rem, r_dvd[DIV_QW-1]};
    assign take  = (trial >= {1'b0, r_div});

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath. The dividend is the input shifted left by 16 bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_SW'(i_dividend[DIV_DW-1:4]);
            r_dvd <= {i_dividend[3:0], 16'd0};
            r_quo <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? DIV_SW'(trial - {1'b0, r_div}) : trial[DIV_SW-1:0];
            r_dvd <= {r_dvd[DIV_QW-2:0], 1'b0};
            r_quo <= {r_quo[DIV_QW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/fuzzy_pd_gain_scheduler.sv -----
// Fuzzy PD gain scheduler.
// Input channel: i_valid, i_error_sample, with o_stall driven back. A word is
// taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid, o_kp_gain, o_kd_gain, with i_stall from the receiver.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle.
// Each word runs through a small sequencer that shares one restoring divider
// (20 steps) and one multiplier (five steps per gain). An axis whose value
// sits at or beyond an end point skips the divider.
// One word is in work at a time; the sequencer returns to idle when it loads
// the result into the output register, and the next word can be taken then.
// o_stall is high while a word is in work.
// A finished result sits in the output register until taken; a new word may
// be accepted meanwhile, and the next result waits until the register frees,
// which adds the stalled cycles to its latency.
// Synchronous reset loads the register defaults, clears the previous error
// and drops o_valid.
`include "assert_macros.svh"

module fuzzy_pd_gain_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_error_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_kp_gain,
    output logic [15:0]        o_kd_gain,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import fpd_pkg::*;

    t_state r_state;

    // Configuration registers.
    logic [14:0] r_efs, r_rfs;
    logic [15:0] r_kp_span, r_kd_span, r_kp_ofs, r_kd_ofs;

    // Work registers.
    logic signed [15:0] r_e, r_prev;
    logic [18:0]        r_ne;
    logic signed [19:0] r_rn;
    logic               r_efirst;
    logic [2:0]         r_ei, r_di;
    logic [16:0]        r_we0, r_we1, r_wd0, r_wd1;
    logic               r_sel;
    logic [34:0]        r_acc;
    logic [18:0]        r_t;
    logic [15:0]        r_q;
    logic [15:0]        r_kp_res, r_kd_res;
    logic               r_ovalid;
    logic [15:0]        r_kp_out, r_kd_out;

    // Divider hookup.
    logic               div_start;
    logic [DIV_DW-1:0]  div_dvd;
    logic [DIV_SW-1:0]  div_dsr;
    logic               div_done;
    logic [DIV_QW-1:0]  div_quo;
    logic [DIV_SW-1:0]  div_rem;

    fpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Effective full scales and their multiples.
    logic [14:0]        emax, dmax;
    logic [17:0]        m7;
    logic [18:0]        m12;
    logic [16:0]        m3;
    logic signed [19:0] m3s;
    assign emax = (r_efs == 15'd0) ? 15'd1 : r_efs;
    assign dmax = (r_rfs == 15'd0) ? 15'd1 : r_rfs;
    assign m7   = {emax, 3'd0} - {3'd0, emax};
    assign m12  = {1'b0, emax, 3'd0} + {2'b0, emax, 2'd0};
    assign m3   = {2'b0, dmax} + {1'b0, dmax, 1'b0};
    assign m3s  = signed'({3'd0, m3});

    // Error magnitude and the mapped error change.
    logic [15:0]        mag;
    logic signed [16:0] dif, difn;
    logic signed [19:0] rn_lin;
    logic               flip;
    always_comb begin
        mag    = r_e[15] ? 16'(-r_e) : 16'(r_e);
        dif    = 17'(signed'({r_e[15], r_e}) - signed'({r_prev[15], r_prev}));
        difn   = r_e[15] ? 17'(-dif) : dif;
        rn_lin = 20'(signed'({{3{difn[16]}}, difn}) + signed'({{2{difn[16]}}, difn, 1'b0}));
        flip   = (r_prev[15] && !r_e[15] && r_e != 16'sd0) ||
                 (!r_prev[15] && r_prev != 16'sd0 && r_e[15]);
    end

    // Divider operands by state.
    logic signed [19:0] rshift;
    always_comb begin
        rshift    = r_rn + m3s;
        div_start = 1'b0;
        div_dvd   = r_ne;
        div_dsr   = {3'd0, emax};
        if (r_state == S_ECLS) begin
            div_start = (r_ne != 19'd0) && (r_ne < m12);
            div_dsr   = (r_ne <= {1'b0, m7}) ? m7 : {3'd0, emax};
        end else if (r_state == S_RCLS) begin
            div_start = (r_rn > -m3s) && (r_rn < m3s);
            div_dvd   = rshift[18:0];
            div_dsr   = {3'd0, dmax};
        end
    end

    // Weights from the quotient. A value exactly on a point takes the
    // interval that ends there.
    logic        exact;
    logic [3:0]  qa;
    logic [16:0] wq;
    always_comb begin
        exact = (div_quo[15:0] == 16'd0) && (div_rem == '0);
        qa    = exact ? div_quo[19:16] - 4'd1 : div_quo[19:16];
        wq    = 17'(div_quo - {qa, 16'd0});
    end

    // Rule lookups and the rate-weighted row sums.
    logic [2:0]  ra0, rb0, ra1, rb1;
    logic [19:0] x0w, x1w;
    always_comb begin
        ra0 = rule_at(r_sel, r_ei, r_di);
        rb0 = rule_at(r_sel, r_ei, r_di + 3'd1);
        ra1 = rule_at(r_sel, r_ei + 3'd1, r_di);
        rb1 = rule_at(r_sel, r_ei + 3'd1, r_di + 3'd1);
        x0w = 20'(r_wd0) * 20'(ra0) + 20'(r_wd1) * 20'(rb0);
        x1w = 20'(r_wd0) * 20'(ra1) + 20'(r_wd1) * 20'(rb1);
    end

    // Shared multiplier.
    logic [31:0] mul_a;
    logic [18:0] mul_b;
    logic [50:0] prod;
    logic [15:0] span, ofs;
    always_comb begin
        span  = r_sel ? r_kd_span : r_kp_span;
        ofs   = r_sel ? r_kd_ofs  : r_kp_ofs;
        mul_a = {15'd0, r_we0};
        mul_b = x0w[18:0];
        unique case (r_state)
            S_GS1: begin
                mul_a = {15'd0, r_we1};
                mul_b = x1w[18:0];
            end
            S_GT: begin
                mul_a = r_acc[31:0];
                mul_b = {3'd0, span};
            end
            S_GQ: begin
                mul_a = {14'd0, r_t[18:1]};
                mul_b = RECIP3;
            end
            default: begin
                mul_a = {15'd0, r_we0};
                mul_b = x0w[18:0];
            end
        endcase
        prod = 51'(mul_a) * 51'(mul_b);
    end

    logic [18:0] t_hi;
    logic [16:0] gsum;
    logic [15:0] gsat;
    logic        out_free;
    assign t_hi     = 19'(r_acc[34:32]) * 19'(span);
    assign gsum     = {1'b0, r_q} + {1'b0, ofs};
    assign gsat     = gsum[16] ? 16'hFFFF : gsum[15:0];
    assign out_free = !r_ovalid || !i_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_efs     <= EFS_RESET;
            r_rfs     <= RFS_RESET;
            r_kp_span <= '0;
            r_kd_span <= '0;
            r_kp_ofs  <= '0;
            r_kd_ofs  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EFS:   r_efs     <= i_cfg_data[14:0];
                CFG_RFS:   r_rfs     <= i_cfg_data[14:0];
                CFG_KPSPN: r_kp_span <= i_cfg_data;
                CFG_KDSPN: r_kd_span <= i_cfg_data;
                CFG_KPOFS: r_kp_ofs  <= i_cfg_data;
                CFG_KDOFS: r_kd_ofs  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_PREP;
                S_PREP: begin
                    r_prev  <= r_e;
                    r_state <= S_ECLS;
                end
                S_ECLS: r_state <= div_start ? S_EDIV : S_RCLS;
                S_EDIV: if (div_done) r_state <= S_EFIN;
                S_EFIN: r_state <= S_RCLS;
                S_RCLS: r_state <= div_start ? S_RDIV : S_GS0;
                S_RDIV: if (div_done) r_state <= S_RFIN;
                S_RFIN: r_state <= S_GS0;
                S_GS0:  r_state <= S_GS1;
                S_GS1:  r_state <= S_GT;
                S_GT:   r_state <= S_GQ;
                S_GQ:   r_state <= S_GADD;
                S_GADD: r_state <= r_sel ? S_DONE : S_GS0;
                S_DONE: if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: r_e <= i_error_sample;
            S_PREP: begin
                r_ne <= 19'({mag, 3'd0} + {1'b0, mag, 2'd0});
                r_rn <= flip ? m3s : rn_lin;
            end
            S_ECLS: begin
                r_efirst <= (r_ne <= {1'b0, m7});
                if (r_ne == 19'd0) begin
                    r_ei  <= 3'd0;
                    r_we0 <= W_ONE;
                    r_we1 <= '0;
                end else if (r_ne >= m12) begin
                    r_ei  <= 3'd5;
                    r_we0 <= '0;
                    r_we1 <= W_ONE;
                end
            end
            S_EFIN: begin
                if (r_efirst) begin
                    r_ei  <= 3'd0;
                    r_we1 <= div_quo[16:0];
                    r_we0 <= W_ONE - div_quo[16:0];
                end else begin
                    r_ei  <= 3'(qa - 4'd6);
                    r_we1 <= wq;
                    r_we0 <= W_ONE - wq;
                end
            end
            S_RCLS: begin
                r_sel <= 1'b0;
                if (r_rn <= -m3s) begin
                    r_di  <= 3'd0;
                    r_wd0 <= W_ONE;
                    r_wd1 <= '0;
                end else if (r_rn >= m3s) begin
                    r_di  <= 3'd5;
                    r_wd0 <= '0;
                    r_wd1 <= W_ONE;
                end
            end
            S_RFIN: begin
                r_di  <= qa[2:0];
                r_wd1 <= wq;
                r_wd0 <= W_ONE - wq;
            end
            S_GS0: r_acc <= prod[34:0];
            S_GS1: r_acc <= r_acc + prod[34:0];
            S_GT:  r_t   <= 19'(prod[50:32] + t_hi);
            S_GQ:  r_q   <= prod[34:19];
            S_GADD: begin
                if (r_sel) begin
                    r_kd_res <= gsat;
                end else begin
                    r_kp_res <= gsat;
                end
                r_sel <= 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_kp_out <= r_kp_res;
                    r_kd_out <= r_kd_res;
                end
            end
            default: ;
        endcase
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_kp_gain = r_kp_out;
    assign o_kd_gain = r_kd_out;

    // Checks on the sequencer and the axis weights.
    `ASSERT_CLK(a_ovalid_src, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state == S_DONE), "o_valid rose outside the done state")
    `ASSERT_NEXT(a_accept_prep, i_clk, i_rst_n, i_valid && !o_stall, r_state == S_PREP, "accepted word did not start work")
    `ASSERT_CLK(a_wsum_e, i_clk, i_rst_n, (r_state == S_GS0) |-> (({1'b0, r_we0} + {1'b0, r_we1}) == {1'b0, W_ONE}), "error weights do not sum to one")
    `ASSERT_CLK(a_wsum_d, i_clk, i_rst_n, (r_state == S_GS0) |-> (({1'b0, r_wd0} + {1'b0, r_wd1}) == {1'b0, W_ONE}), "rate weights do not sum to one")

endmodule

// ----- bench/gain_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the gain scheduler, predicts each gain pair and
// compares it with what the block delivers.
module gain_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic signed [15:0] i_error_sample,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [15:0]        i_kp_gain,
    input  logic [15:0]        i_kd_gain,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results
);
    import fpd_pkg::*;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] kd;
    } t_gains;

    // Fuzzy rule tables, error point by rate point.
    localparam int KP_TBL [7][7] = '{
        '{0,0,0,0,0,0,0}, '{1,1,1,1,1,1,1}, '{1,1,1,2,3,3,3},
        '{2,2,3,3,3,4,4}, '{3,3,4,4,4,5,5}, '{4,5,5,5,5,5,6},
        '{6,6,6,6,6,6,6}};
    localparam int KD_TBL [7][7] = '{
        '{6,5,4,4,4,3,2}, '{6,5,4,4,4,3,2}, '{6,5,4,3,3,2,2},
        '{5,4,3,3,2,2,1}, '{4,3,3,3,2,1,0}, '{3,3,3,2,2,1,0},
        '{3,3,3,2,2,1,0}};
    localparam int ERR_PTS [7] = '{0, 7, 8, 9, 10, 11, 12};
    localparam int RATE_PTS [7] = '{-3, -2, -1, 0, 1, 2, 3};

    logic [14:0] err_fs, rate_fs;
    logic [15:0] kp_span, kd_span, kp_ofs, kd_ofs;
    logic signed [15:0] last_error;
    t_gains gains_due [$];

    // Splits value n/m between two neighboring axis points.
    task automatic split_axis(input longint n, input longint m, input bit is_err,
                              output int idx, output longint w_lo, output longint w_hi);
        longint a, b;
        longint p0, p6;
        p0 = (is_err ? ERR_PTS[0] : RATE_PTS[0]) * m;
        p6 = (is_err ? ERR_PTS[6] : RATE_PTS[6]) * m;
        idx = 0; w_lo = 65536; w_hi = 0;
        if (n <= p0) return;
        if (n >= p6) begin
            idx = 5; w_lo = 0; w_hi = 65536;
            return;
        end
        for (int i = 0; i < 6; i++) begin
            a = (is_err ? ERR_PTS[i] : RATE_PTS[i]) * m;
            b = (is_err ? ERR_PTS[i+1] : RATE_PTS[i+1]) * m;
            if (a < n && n <= b) begin
                idx = i;
                w_hi = ((n - a) * 65536) / (b - a);
                w_lo = 65536 - w_hi;
                return;
            end
        end
    endtask

    function automatic logic [15:0] blend(input bit use_kd, input int ei, input longint e0,
                                          input longint e1, input int di, input longint d0,
                                          input longint d1, input longint span,
                                          input longint ofs);
        longint unsigned s, g;
        if (use_kd)
            s = e0*d0*KD_TBL[ei][di] + e0*d1*KD_TBL[ei][di+1]
              + e1*d0*KD_TBL[ei+1][di] + e1*d1*KD_TBL[ei+1][di+1];
        else
            s = e0*d0*KP_TBL[ei][di] + e0*d1*KP_TBL[ei][di+1]
              + e1*d0*KP_TBL[ei+1][di] + e1*d1*KP_TBL[ei+1][di+1];
        // s stays at or below 6*2^32 and span below 2^16, so the product fits.
        g = (s * span) / (64'd6 << 32) + ofs;
        return (g > 65535) ? 16'hFFFF : g[15:0];
    endfunction

    task automatic predict_gains(input logic signed [15:0] err);
        longint e, p, d, emax, dmax, mag, rate_n, ew0, ew1, dw0, dw1;
        int ei, di;
        t_gains g;
        e = err;
        p = last_error;
        d = e - p;
        emax = (err_fs == 0) ? 1 : err_fs;
        dmax = (rate_fs == 0) ? 1 : rate_fs;
        mag = (e < 0) ? -e : e;
        if (e < 0) d = -d;
        rate_n = d * 3;
        // A sign reversal pushes the rate to the top of its universe.
        if ((p < 0 && e > 0) || (p > 0 && e < 0)) rate_n = 3 * dmax;
        split_axis(mag * 12, emax, 1'b1, ei, ew0, ew1);
        split_axis(rate_n, dmax, 1'b0, di, dw0, dw1);
        g.kp = blend(1'b0, ei, ew0, ew1, di, dw0, dw1, kp_span, kp_ofs);
        g.kd = blend(1'b1, ei, ew0, ew1, di, dw0, dw1, kd_span, kd_ofs);
        gains_due.push_back(g);
        last_error = err;
    endtask

    // Track configuration, accept words and compare results at each rising edge.
    always @(posedge i_clk) begin
        t_gains want;
        if (!i_rst_n) begin
            err_fs <= EFS_RESET; rate_fs <= RFS_RESET;
            kp_span <= '0; kd_span <= '0; kp_ofs <= '0; kd_ofs <= '0;
            last_error = '0;
            gains_due.delete();
            o_fail_count <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EFS: begin
                        err_fs <= i_cfg_data[14:0];
                    end
                    CFG_RFS: begin
                        rate_fs <= i_cfg_data[14:0];
                    end
                    CFG_KPSPN: begin
                        kp_span <= i_cfg_data;
                    end
                    CFG_KDSPN: begin
                        kd_span <= i_cfg_data;
                    end
                    CFG_KPOFS: begin
                        kp_ofs <= i_cfg_data;
                    end
                    CFG_KDOFS: begin
                        kd_ofs <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (gains_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected word: kp=%h kd=%h", i_kp_gain, i_kd_gain);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = gains_due.pop_front();
                    if (want.kp !== i_kp_gain || want.kd !== i_kd_gain) begin
                        if (o_fail_count < 10)
                            $display("mismatch: kp exp %h got %h, kd exp %h got %h",
                                     want.kp, i_kp_gain, want.kd, i_kd_gain);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) predict_gains(i_error_sample);
            o_pending <= gains_due.size();
        end
    end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import fpd_pkg::*;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] error_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        kp_gain, kd_gain;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_idx = CFG_EFS;
    logic [15:0]        cfg_data = '0;
    int                 fail_count, pending, results;
    bit                 hold_rx = 1'b0;
    int                 sent = 0;

    always #5 i_clk = ~i_clk;

    fuzzy_pd_gain_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_error_sample(error_word), .o_valid(out_valid), .i_stall(out_stall),
        .o_kp_gain(kp_gain), .o_kd_gain(kd_gain), .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    gain_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_error_sample(error_word), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_kp_gain(kp_gain), .i_kd_gain(kd_gain), .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data), .o_fail_count(fail_count),
        .o_pending(pending), .o_results(results)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // Receiver stalls at random outside two stall-free windows of sent words, or holds off fully while hold_rx is set.
    always @(negedge i_clk) begin
        if (hold_rx) out_stall <= 1'b1;
        else if (sent < 60 || (sent > 300 && sent < 360)) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < 30);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every result has come, then lets the block settle.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // Offers one word and holds it until accepted; optional gap before it.
    task automatic send_word(input logic signed [15:0] val, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        error_word <= val;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic set_all(input logic [14:0] efs, input logic [14:0] rfs,
                           input logic [15:0] kps, input logic [15:0] kds,
                           input logic [15:0] kpo, input logic [15:0] kdo);
        in_valid <= 1'b0;
        drain();
        write_reg(CFG_EFS, {1'b0, efs});
        write_reg(CFG_RFS, {1'b0, rfs});
        write_reg(CFG_KPSPN, kps);
        write_reg(CFG_KDSPN, kds);
        write_reg(CFG_KPOFS, kpo);
        write_reg(CFG_KDOFS, kdo);
    endtask

    // Random error: mostly near the configured scale, sometimes anything.
    function automatic logic signed [15:0] rand_error(input int efs);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($signed($urandom_range(0, 2 * efs + 2)) - efs - 1);
        if (r < 8) return 16'($signed($urandom_range(0, 60)) - 30);
        return 16'($urandom());
    endfunction

    // Holds off the receiver fully by setting hold_rx, then releases it.
    task automatic long_hold();
        hold_rx = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_rx = 1'b0;
    endtask

    initial begin
        int efs;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, then edge values and sign changes.
        send_word(16'sd0, 1'b0);
        send_word(16'sd30, 1'b0);
        send_word(-16'sd30, 1'b0);
        set_all(15'd100, 15'd20, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        write_reg(CFG_SPARE_LO, 16'h1234);
        send_word(16'sd0, 1'b0);
        send_word(16'sd58, 1'b0);
        send_word(16'sd67, 1'b0);
        send_word(16'sd75, 1'b0);
        send_word(16'sd83, 1'b0);
        send_word(16'sd92, 1'b0);
        send_word(16'sd100, 1'b0);
        send_word(16'sd90, 1'b0);
        send_word(-16'sd90, 1'b0);
        send_word(16'sd40, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd1, 1'b0);
        set_all(15'd0, 15'd0, 16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFFF);
        send_word(16'sd5, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(16'sh5555, 1'b0);
        set_all(15'h7FFF, 15'h7FFF, 16'h0100, 16'h0080, 16'h0000, 16'h0200);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh2AAA, 1'b0);

        // Random phases under changing settings.
        for (int ph = 0; ph < 6; ph++) begin
            efs = (ph == 5) ? 32767 : $urandom_range(1, 2000);
            set_all(15'(efs), (ph == 4) ? 15'd1 : 15'($urandom_range(1, 1000)),
                    16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 600)),
                    (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 600)));
            for (int k = 0; k < 88; k++) begin
                if (ph == 2 && k == 10) begin
                    fork
                        long_hold();
                    join_none
                end
                if (ph == 3 && k == 40) begin
                    in_valid <= 1'b0;
                    @(negedge i_clk);
                    while (pending != 0) @(negedge i_clk);
                end
                send_word(rand_error(efs), 1'b1);
            end
        end
        in_valid <= 1'b0;
        drain();
        $display("Sent %0d error words over ten register settings; %0d gain pairs checked.",
                 sent, results);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
